// ----- rtl/core/deq_pkg.sv -----
// shared types, constants and pointer helpers for the double-ended queue
// no dependencies

package deq_pkg;

    localparam int DEPTH = 1024;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 64;

    localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FN_POP_FRONT  = 3'd2;
    localparam logic [2:0] FN_POP_BACK   = 3'd3;
    localparam logic [2:0] FN_QUERY      = 3'd4;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     popped_valid;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [10:0]              count;
        logic                     is_empty;
        logic                     rejected;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_rd;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_read;
    } t_dp_status;

    function automatic t_ptr ptr_inc(input t_ptr p);
        return (p == t_ptr'(DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_dec(input t_ptr p);
        return (p == '0) ? t_ptr'(DEPTH - 1) : p - t_ptr'(1);
    endfunction

endpackage

// ----- rtl/core/deq_ctrl.sv -----
// sequencing state machine for the double-ended queue
// depends on deq_pkg

module deq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  deq_pkg::t_dp_status i_status,
    output deq_pkg::t_ctl_cmd   o_cmd,
    output logic                o_busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_read ? ST_WAIT : ST_IDLE;
            end
            ST_WAIT: begin
                // memory read data is registered by now
                o_cmd.load_rd = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ----- rtl/core/deq_dpath.sv -----
// datapath of the double-ended queue: slot memory, pointers, count and
// cached front/back values; depends on deq_pkg

module deq_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  deq_pkg::t_ctl_cmd   i_cmd,
    input  deq_pkg::t_item      i_item,
    output deq_pkg::t_dp_status o_status,
    output deq_pkg::t_result    o_result,
    output logic                o_done
);

    logic [deq_pkg::DATA_W-1:0] mem [deq_pkg::DEPTH];

    logic [2:0]                 r_func;
    logic [deq_pkg::DATA_W-1:0] r_value;

    deq_pkg::t_ptr              r_head;
    deq_pkg::t_ptr              r_tail;
    deq_pkg::t_cnt              r_count;
    logic [deq_pkg::DATA_W-1:0] r_front;
    logic [deq_pkg::DATA_W-1:0] r_back;
    logic [deq_pkg::DATA_W-1:0] r_popped;
    logic                       r_pvalid;
    logic                       r_rej;
    logic                       r_rd_front;
    logic [deq_pkg::DATA_W-1:0] r_rdata;
    logic                       r_done;

    deq_pkg::t_ptr              n_head;
    deq_pkg::t_ptr              n_tail;
    deq_pkg::t_cnt              n_count;
    logic [deq_pkg::DATA_W-1:0] n_front;
    logic [deq_pkg::DATA_W-1:0] n_back;
    logic [deq_pkg::DATA_W-1:0] n_popped;
    logic                       n_pvalid;
    logic                       n_rej;
    logic                       n_rd_front;
    logic                       need_read;
    logic                       wr_en;
    deq_pkg::t_ptr              waddr;
    deq_pkg::t_ptr              raddr;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_front    = r_front;
        n_back     = r_back;
        n_popped   = '0;
        n_pvalid   = 1'b0;
        n_rej      = 1'b0;
        n_rd_front = 1'b0;
        need_read  = 1'b0;
        wr_en      = 1'b0;
        waddr      = r_tail;
        raddr      = deq_pkg::ptr_inc(r_head);
        case (r_func)
            deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
                if (r_count == deq_pkg::t_cnt'(deq_pkg::DEPTH)) begin
                    n_rej = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + deq_pkg::t_cnt'(1);
                    if (r_func == deq_pkg::FN_PUSH_FRONT) begin
                        n_head  = deq_pkg::ptr_dec(r_head);
                        waddr   = n_head;
                        n_front = r_value;
                        if (r_count == '0) begin
                            n_back = r_value;
                        end
                    end else begin
                        n_tail = deq_pkg::ptr_inc(r_tail);
                        waddr  = r_tail;
                        n_back = r_value;
                        if (r_count == '0) begin
                            n_front = r_value;
                        end
                    end
                end
            end
            deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_BACK: begin
                if (r_count == '0) begin
                    n_rej = 1'b1;
                end else begin
                    n_pvalid = 1'b1;
                    n_count  = r_count - deq_pkg::t_cnt'(1);
                    if (r_func == deq_pkg::FN_POP_FRONT) begin
                        n_popped = r_front;
                        n_head   = deq_pkg::ptr_inc(r_head);
                        raddr    = n_head;
                        if (r_count == deq_pkg::t_cnt'(1)) begin
                            n_front = '0;
                            n_back  = '0;
                        end else if (r_count == deq_pkg::t_cnt'(2)) begin
                            n_front = r_back;
                        end else begin
                            // new front comes from the slot memory
                            need_read  = 1'b1;
                            n_rd_front = 1'b1;
                        end
                    end else begin
                        n_popped = r_back;
                        n_tail   = deq_pkg::ptr_dec(r_tail);
                        raddr    = deq_pkg::ptr_dec(n_tail);
                        if (r_count == deq_pkg::t_cnt'(1)) begin
                            n_front = '0;
                            n_back  = '0;
                        end else if (r_count == deq_pkg::t_cnt'(2)) begin
                            n_back = r_front;
                        end else begin
                            need_read = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // query and unused codes leave the state alone
            end
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[waddr] <= r_value;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_item.func;
            r_value <= i_item.value;
        end
        if (i_cmd.exec) begin
            r_popped   <= n_popped;
            r_pvalid   <= n_pvalid;
            r_rej      <= n_rej;
            r_rd_front <= n_rd_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_front <= '0;
            r_back  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (i_cmd.exec && !need_read) || i_cmd.load_rd;
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_front <= n_front;
                r_back  <= n_back;
            end else if (i_cmd.load_rd) begin
                if (r_rd_front) begin
                    r_front <= r_rdata;
                end else begin
                    r_back <= r_rdata;
                end
            end
        end
    end

    assign o_status.need_read = need_read;
    assign o_done             = r_done;

    assign o_result.popped_value = r_popped;
    assign o_result.popped_valid = r_pvalid;
    assign o_result.front_value  = r_front;
    assign o_result.back_value   = r_back;
    assign o_result.count        = r_count;
    assign o_result.is_empty     = (r_count == '0);
    assign o_result.rejected     = r_rej;

endmodule

// ----- rtl/core/double_ended_queue_core.sv -----
// double-ended queue of signed 64-bit values in a 1024-slot circular store
// latency: result strobe 2 cycles after accept, 3 when a pop must read the
// next front/back value from the slot memory (single registered read port)
// throughput: one item every 2 or 3 cycles; busy drops with the result strobe
// the receiver cannot stall; synchronous active-low reset empties the queue,
// no clearing pass is needed

module double_ended_queue_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  deq_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_done,
    output deq_pkg::t_result o_result
);

    deq_pkg::t_ctl_cmd   ctl_cmd;
    deq_pkg::t_dp_status dp_status;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (ctl_cmd),
        .o_busy   (busy)
    );

    deq_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ctl_cmd),
        .i_item   (i_item),
        .o_status (dp_status),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

// ----- rtl/core/deq_checker.sv -----
// port-level checks for the double-ended queue core, bound to the top level
// depends on deq_pkg and double_ended_queue_core

module deq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input deq_pkg::t_result o_result
);

    // an item in flight keeps the core busy until its result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting an item");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an item in flight");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.is_empty == (o_result.count == '0)) &&
                   (o_result.count <= 11'(deq_pkg::DEPTH)))
        else $error("count and empty flag disagree");

    a_reject_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.rejected) |-> !o_result.popped_valid)
        else $error("rejected item reports a popped value");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
